/* hdl/vcpc_pkg.sv */
// Shared types and constants of the class-pair count matrix block.
package vcpc_pkg;

  localparam int TableEntries = 16;
  localparam int VectorCoords = 4;
  localparam int CoordBits    = 16;
  localparam int CountBits    = 32;
  localparam int LabelBits    = 40;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int AddrBits     = 2 * IdxBits;
  localparam int Cells        = TableEntries * TableEntries;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpCount = 2'd1,
    OpRead  = 2'd2,
    OpClear = 2'd3
  } op_e;

  typedef logic [CoordBits-1:0]       coord_t;
  typedef coord_t [VectorCoords-1:0]  vec_t;
  typedef logic [LabelBits-1:0]       label_t;
  typedef logic [IdxBits-1:0]         idx_t;
  typedef logic [CountBits-1:0]       count_t;

  localparam count_t CountMax = {CountBits{1'b1}};

  // Classifier result for one vector.
  typedef struct packed {
    logic hit;
    idx_t cls;
  } match_t;

endpackage

/* hdl/vector_class_pair_count_matrix_top.sv */
// Top level of the class-pair count matrix: entry table, phase tracking, count memory.
// Pipeline: input register at the accepting edge, then match/read stage, then
//   result register.
// Throughput: one transaction per cycle unless out_ready_i stalls; the count memory does
//   one registered read and one write per cycle, with forwarding of the write just made.
// Reset: clears valid bits of table and matrix, phase and pipeline control;
//   the table contents and the count memory itself are not swept.
module vector_class_pair_count_matrix_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  vcpc_pkg::idx_t           entry_index_i,
  input  vcpc_pkg::coord_t         coord_0_i,
  input  vcpc_pkg::coord_t         coord_1_i,
  input  vcpc_pkg::coord_t         coord_2_i,
  input  vcpc_pkg::coord_t         coord_3_i,
  input  vcpc_pkg::label_t         entry_label_i,
  input  vcpc_pkg::idx_t           row_select_i,
  input  vcpc_pkg::idx_t           col_select_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output vcpc_pkg::count_t         cell_value_o,
  output logic                     found_o,
  output vcpc_pkg::idx_t           class_index_o,
  output logic                     pair_counted_o,
  output logic                     was_future_o
);
  import vcpc_pkg::*;

  // ---------------------------------------------------------------
  // Stage handshake: each stage moves when the next is empty or moving.
  // ---------------------------------------------------------------
  logic en_out, en_s2, en_s1;
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic move1, move2;

  assign en_out = !out_valid_q || out_ready_i;
  assign en_s2  = !s2_valid_q || en_out;
  assign en_s1  = !s1_valid_q || en_s2;
  assign move1  = s1_valid_q && en_s2;
  assign move2  = s2_valid_q && en_out;

  assign in_ready_o  = en_s1;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1)  s1_valid_q  <= in_valid_i;
      if (en_s2)  s2_valid_q  <= s1_valid_q;
      if (en_out) out_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  op_e    s1_op_q;
  idx_t   s1_index_q;
  vec_t   s1_vec_q;
  label_t s1_label_q;
  idx_t   s1_row_q;
  idx_t   s1_col_q;

  always_ff @(posedge clk_i) begin
    if (en_s1 && in_valid_i) begin
      s1_op_q     <= op_e'(operation_i);
      s1_index_q  <= entry_index_i;
      s1_vec_q[0] <= coord_0_i;
      s1_vec_q[1] <= coord_1_i;
      s1_vec_q[2] <= coord_2_i;
      s1_vec_q[3] <= coord_3_i;
      s1_label_q  <= entry_label_i;
      s1_row_q    <= row_select_i;
      s1_col_q    <= col_select_i;
    end
  end

  // ---------------------------------------------------------------
  // Entry table: contents without reset, valid bits with reset.
  // Loads take effect as the transaction leaves the input register.
  // ---------------------------------------------------------------
  vec_t   [TableEntries-1:0] tbl_vec_q;
  label_t [TableEntries-1:0] tbl_label_q;
  logic   [TableEntries-1:0] tbl_valid_q;
  logic                      do_load;

  assign do_load = move1 && (s1_op_q == OpLoad);

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      tbl_vec_q[s1_index_q]   <= s1_vec_q;
      tbl_label_q[s1_index_q] <= s1_label_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_valid_q <= '0;
    end else if (do_load) begin
      tbl_valid_q[s1_index_q] <= 1'b1;
    end
  end

  match_t s1_match;

  vcpc_match u_match (
    .query_i       (s1_vec_q),
    .entry_vec_i   (tbl_vec_q),
    .entry_label_i (tbl_label_q),
    .entry_valid_i (tbl_valid_q),
    .match_o       (s1_match)
  );

  // ---------------------------------------------------------------
  // Past/future phase, updated as a count or clear leaves stage 1.
  // ---------------------------------------------------------------
  logic phase_q;      // high: next count takes the future role
  idx_t past_class_q;
  logic past_found_q;
  logic s1_count, s1_future, s1_inc;

  assign s1_count  = (s1_op_q == OpCount);
  assign s1_future = s1_count && phase_q;
  assign s1_inc    = s1_future && s1_match.hit && past_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= 1'b0;
      past_class_q <= '0;
      past_found_q <= 1'b0;
    end else if (move1) begin
      if (s1_op_q == OpClear) begin
        phase_q      <= 1'b0;
        past_class_q <= '0;
        past_found_q <= 1'b0;
      end else if (s1_count) begin
        if (!phase_q) begin
          past_class_q <= s1_match.cls;
          past_found_q <= s1_match.hit;
          phase_q      <= 1'b1;
        end else begin
          phase_q <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Count memory: registered read issued from stage 1, write from
  // stage 2. Per-cell valid bits give the zero reset and the clear.
  // ---------------------------------------------------------------
  logic [AddrBits-1:0] rd_addr;
  count_t              mem_q [Cells];
  count_t              rd_data_q;
  logic [Cells-1:0]    cell_valid_q;

  assign rd_addr = (s1_op_q == OpRead) ? {s1_row_q, s1_col_q}
                                       : {past_class_q, s1_match.cls};

  // stage 2 registers
  op_e                 s2_op_q;
  logic [AddrBits-1:0] s2_addr_q;
  logic                s2_inc_q;
  logic                s2_found_q;
  idx_t                s2_cls_q;
  logic                s2_future_q;
  logic                s2_fwd_q;
  count_t              s2_fwd_data_q;
  count_t              s2_cur;
  count_t              s2_next;
  logic                s2_write;

  assign s2_cur   = s2_fwd_q ? s2_fwd_data_q
                  : (cell_valid_q[s2_addr_q] ? rd_data_q : '0);
  assign s2_next  = (s2_cur == CountMax) ? s2_cur : s2_cur + count_t'(1);
  assign s2_write = move2 && s2_inc_q;

  always_ff @(posedge clk_i) begin
    if (s2_write) mem_q[s2_addr_q] <= s2_next;
    if (move1)    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= '0;
    end else if (move2) begin
      if (s2_op_q == OpClear) begin
        cell_valid_q <= '0;
      end else if (s2_inc_q) begin
        cell_valid_q[s2_addr_q] <= 1'b1;
      end
    end
  end

  // memory reads old data when the same cell is written at that edge
  always_ff @(posedge clk_i) begin
    if (move1) begin
      s2_op_q       <= s1_op_q;
      s2_addr_q     <= rd_addr;
      s2_inc_q      <= s1_inc;
      s2_found_q    <= s1_count && s1_match.hit;
      s2_cls_q      <= s1_count ? s1_match.cls : '0;
      s2_future_q   <= s1_future;
      s2_fwd_q      <= s2_write && (s2_addr_q == rd_addr);
      s2_fwd_data_q <= s2_next;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  count_t out_cell_q;
  logic   out_found_q;
  idx_t   out_cls_q;
  logic   out_counted_q;
  logic   out_future_q;

  always_ff @(posedge clk_i) begin
    if (move2) begin
      out_cell_q    <= s2_inc_q ? s2_next
                     : ((s2_op_q == OpRead) ? s2_cur : '0);
      out_found_q   <= s2_found_q;
      out_cls_q     <= s2_cls_q;
      out_counted_q <= s2_inc_q;
      out_future_q  <= s2_future_q;
    end
  end

  assign cell_value_o   = out_cell_q;
  assign found_o        = out_found_q;
  assign class_index_o  = out_cls_q;
  assign pair_counted_o = out_counted_q;
  assign was_future_o   = out_future_q;

endmodule

/* hdl/vcpc_match.sv */
// Parallel table match and label-class lookup for one vector.
module vcpc_match (
  input  vcpc_pkg::vec_t                              query_i,
  input  vcpc_pkg::vec_t [vcpc_pkg::TableEntries-1:0] entry_vec_i,
  input  vcpc_pkg::label_t [vcpc_pkg::TableEntries-1:0] entry_label_i,
  input  logic [vcpc_pkg::TableEntries-1:0]           entry_valid_i,
  output vcpc_pkg::match_t                            match_o
);
  import vcpc_pkg::*;

  logic [TableEntries-1:0] hit;
  logic [TableEntries-1:0] same;
  idx_t                    win;
  label_t                  win_label;
  idx_t                    cls;

  always_comb begin
    for (int j = 0; j < TableEntries; j++) begin
      hit[j] = entry_valid_i[j] && (entry_vec_i[j] == query_i);
    end
  end

  // lowest matching entry wins
  always_comb begin
    win = '0;
    for (int j = TableEntries - 1; j >= 0; j--) begin
      if (hit[j]) win = idx_t'(j);
    end
  end

  assign win_label = entry_label_i[win];

  always_comb begin
    for (int k = 0; k < TableEntries; k++) begin
      same[k] = entry_valid_i[k] && (entry_label_i[k] == win_label);
    end
  end

  // class is the lowest valid entry sharing the winner's label
  always_comb begin
    cls = '0;
    for (int k = TableEntries - 1; k >= 0; k--) begin
      if (same[k]) cls = idx_t'(k);
    end
  end

  assign match_o.hit = |hit;
  assign match_o.cls = (|hit) ? cls : '0;

endmodule

/* tb/sv/tb_vector_class_pair_count_matrix_top.sv */
// Testbench for the class-pair count matrix: directed and random traffic checked against a predictor.
`timescale 1ns / 100ps

module tb_vector_class_pair_count_matrix_top;
  import vcpc_pkg::*;

  localparam int CycleLimit  = 400000;  // covers ~2100 transactions with a wide margin
  localparam int RandomItems = 2000;
  localparam int DrainCycles = 8;       // three-stage pipe plus margin
  localparam int PrintLimit  = 40;
  localparam int VecPool     = 24;
  localparam int LabelPool   = 5;

  // One input transaction, one field per port.
  typedef struct {
    op_e    op;
    idx_t   slot;
    vec_t   vec;
    label_t label;
    idx_t   row;
    idx_t   col;
  } item_t;

  // One result transaction.
  typedef struct {
    count_t value;
    logic   found;
    idx_t   cls;
    logic   counted;
    logic   fut;
  } result_t;

  logic   clk_i     = 1'b0;
  logic   rst_ni    = 1'b0;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  op_e    in_op     = OpLoad;
  idx_t   in_slot   = '0;
  vec_t   in_vec    = '0;
  label_t in_label  = '0;
  idx_t   in_row    = '0;
  idx_t   in_col    = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  count_t cell_value;
  logic   found;
  idx_t   class_index;
  logic   pair_counted;
  logic   was_future;

  // Predictor state: entry table, count matrix and the past/future pairing.
  vec_t    ent_vec   [TableEntries];
  label_t  ent_label [TableEntries];
  logic    ent_valid [TableEntries];
  count_t  pair_cnt  [TableEntries][TableEntries];
  logic    future_role;
  idx_t    past_cls;
  logic    past_hit;
  result_t pair_results[$];  // predicted results, oldest first

  int errors    = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  bit gaps_on   = 1'b1;

  // result side stall pattern state
  int mode_left = 0;
  int rx_mode   = 0;
  int rx_tick   = 0;

  always #5 clk_i = ~clk_i;

  vector_class_pair_count_matrix_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (in_op),
    .entry_index_i  (in_slot),
    .coord_0_i      (in_vec[0]),
    .coord_1_i      (in_vec[1]),
    .coord_2_i      (in_vec[2]),
    .coord_3_i      (in_vec[3]),
    .entry_label_i  (in_label),
    .row_select_i   (in_row),
    .col_select_i   (in_col),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .cell_value_o   (cell_value),
    .found_o        (found),
    .class_index_o  (class_index),
    .pair_counted_o (pair_counted),
    .was_future_o   (was_future)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Matrix and pairing go back to zero; the entry table is untouched.
  function automatic void clear_pair_counts();
    foreach (pair_cnt[r, c]) pair_cnt[r][c] = '0;
    future_role = 1'b0;
    past_cls    = '0;
    past_hit    = 1'b0;
  endfunction

  // First valid entry with an equal vector wins; its class is the lowest valid
  // entry carrying the same label (the winner itself at worst).
  function automatic match_t lookup_class(vec_t v);
    match_t m;
    m = '0;
    for (int j = 0; j < TableEntries; j++) begin
      if (ent_valid[j] && ent_vec[j] == v) begin
        for (int k = 0; k <= j; k++) begin
          if (ent_valid[k] && ent_label[k] == ent_label[j]) begin
            m.hit = 1'b1;
            m.cls = idx_t'(k);
            return m;
          end
        end
      end
    end
    return m;
  endfunction

  // Applies one accepted transaction to the predictor and returns its result.
  function automatic result_t step_pair_counts(item_t it);
    result_t r;
    match_t  m;
    r = '{default: '0};
    unique case (it.op)
      OpLoad: begin
        ent_vec[it.slot]   = it.vec;
        ent_label[it.slot] = it.label;
        ent_valid[it.slot] = 1'b1;
      end
      OpCount: begin
        m       = lookup_class(it.vec);
        r.found = m.hit;
        r.cls   = m.hit ? m.cls : '0;
        if (!future_role) begin
          past_cls    = m.hit ? m.cls : '0;
          past_hit    = m.hit;
          future_role = 1'b1;
        end else begin
          r.fut = 1'b1;
          // Either side unmatched: the pair is skipped but the phase still flips.
          if (m.hit && past_hit) begin
            // Saturating increment; the top is out of reach in a run this long.
            if (pair_cnt[past_cls][m.cls] != CountMax)
              pair_cnt[past_cls][m.cls] = pair_cnt[past_cls][m.cls] + count_t'(1);
            r.value   = pair_cnt[past_cls][m.cls];
            r.counted = 1'b1;
          end
          future_role = 1'b0;
        end
      end
      OpRead:  r.value = pair_cnt[it.row][it.col];
      default: clear_pair_counts();
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on input handshakes, compare on output handshakes.
  // Both channels are sampled at the clock edge, before the NBA updates land.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= PrintLimit)
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    item_t   acc;
    result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        acc.op    = in_op;
        acc.slot  = in_slot;
        acc.vec   = in_vec;
        acc.label = in_label;
        acc.row   = in_row;
        acc.col   = in_col;
        pair_results.push_back(step_pair_counts(acc));
      end
      if (out_valid && out_ready) begin
        if (pair_results.size() == 0) begin
          errors++;
          if (errors <= PrintLimit)
            $display("%0t: result with no transaction pending: expected none, actual cell %0h",
                     $time, cell_value);
        end else begin
          want = pair_results.pop_front();
          check_field("cell_value", 40'(want.value), 40'(cell_value));
          check_field("found", 40'(want.found), 40'(found));
          check_field("class_index", 40'(want.cls), 40'(class_index));
          check_field("pair_counted", 40'(want.counted), 40'(pair_counted));
          check_field("was_future", 40'(want.fut), 40'(was_future));
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("vector_class_pair_count_matrix_top test failed");
      $finish;
    end
  end

  // Result side back-pressure: modes of random length. Mode 3 holds ready low
  // for the larger part of each period of rx_tick.
  always @(posedge clk_i) begin : rx_stall
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    rx_tick++;
    unique case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rx_tick % 7) != 3;
      default: out_ready <= (rx_tick % 16) < 4;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vec_t rand_vec();
    vec_t v;
    for (int i = 0; i < VectorCoords; i++) v[i] = coord_t'($urandom_range(0, 65535));
    return v;
  endfunction

  function automatic label_t rand_label();
    return label_t'({$urandom(), $urandom()});
  endfunction

  // Unused fields carry random junk so every port bit toggles.
  function automatic item_t rand_item(op_e op);
    item_t it;
    it.op    = op;
    it.slot  = idx_t'($urandom_range(0, 15));
    it.vec   = rand_vec();
    it.label = rand_label();
    it.row   = idx_t'($urandom_range(0, 15));
    it.col   = idx_t'($urandom_range(0, 15));
    return it;
  endfunction

  // Sends one transaction. Valid stays high into the next call, so back-to-back
  // sends never drop it; a gap lowers it first, in a step of its own.
  task automatic send_item(item_t it);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_op    <= it.op;
    in_slot  <= it.slot;
    in_vec   <= it.vec;
    in_label <= it.label;
    in_row   <= it.row;
    in_col   <= it.col;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic load_entry(idx_t slot, vec_t v, label_t l);
    item_t it;
    it       = rand_item(OpLoad);
    it.slot  = slot;
    it.vec   = v;
    it.label = l;
    send_item(it);
  endtask

  task automatic count_vec(vec_t v);
    item_t it;
    it     = rand_item(OpCount);
    it.vec = v;
    send_item(it);
  endtask

  task automatic read_cell(idx_t r, idx_t c);
    item_t it;
    it     = rand_item(OpRead);
    it.row = r;
    it.col = c;
    send_item(it);
  endtask

  task automatic clear_matrix();
    send_item(rand_item(OpClear));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  localparam vec_t VecZero = '0;
  localparam vec_t VecOnes = '1;
  localparam vec_t VecA    = {16'hdef0, 16'h9abc, 16'h5678, 16'h1234};
  localparam vec_t VecB    = {16'h0f0f, 16'hf0f0, 16'h00ff, 16'hff00};
  localparam vec_t VecMiss = {16'h0000, 16'h0000, 16'h0000, 16'h0001};

  // Empty table: matrix reads zero, every count misses, nothing gets counted.
  task automatic test_empty_table();
    read_cell(idx_t'(0), idx_t'(0));
    read_cell(idx_t'(15), idx_t'(15));
    count_vec(VecZero);
    count_vec(VecOnes);
  endtask

  // Extremes of slot, coordinates and label; shared labels fold classes to the
  // lowest slot, and a duplicated vector resolves to its lowest slot.
  task automatic test_load_and_classify();
    load_entry(idx_t'(0), VecZero, '0);
    load_entry(idx_t'(15), VecOnes, '1);
    load_entry(idx_t'(6), VecA, '1);
    load_entry(idx_t'(9), VecA, label_t'(40'h55_aa55_aa55));
    load_entry(idx_t'(3), VecB, '0);
  endtask

  // Matched pairs count; an unmatched past or future side skips the pair.
  task automatic test_pair_counting();
    count_vec(VecOnes);   // past, class 6
    count_vec(VecB);      // future, class 0 -> (6,0) = 1
    count_vec(VecA);      // past, class 6
    count_vec(VecZero);   // future, class 0 -> (6,0) = 2
    count_vec(VecMiss);   // unmatched past
    count_vec(VecB);      // future found but skipped
    count_vec(VecA);      // past
    count_vec(VecMiss);   // unmatched future, skipped
    read_cell(idx_t'(6), idx_t'(0));
  endtask

  // Clear in mid-pair restarts on a past role and zeroes the matrix.
  task automatic test_clear();
    count_vec(VecA);
    clear_matrix();
    count_vec(VecB);      // past again, class 0
    count_vec(VecOnes);   // future, class 6 -> (0,6) = 1
    read_cell(idx_t'(6), idx_t'(0));
    read_cell(idx_t'(0), idx_t'(6));
  endtask

  // Mostly counts of vectors drawn from the loaded pool, so pairs land on a
  // few hot cells; reads aim at those cells; rare clears and random misses.
  task automatic test_random_traffic();
    vec_t   vec_pool[VecPool];
    label_t label_pool[LabelPool];
    match_t mr;
    match_t mc;
    int     sel;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 500 == 0) begin
        foreach (vec_pool[i]) vec_pool[i] = rand_vec();
        foreach (label_pool[i]) label_pool[i] = rand_label();
        for (int s = 0; s < TableEntries; s++)
          load_entry(idx_t'(s), vec_pool[$urandom_range(0, VecPool - 1)],
                     label_pool[$urandom_range(0, LabelPool - 1)]);
      end
      // Every fourth stretch of 200 runs without sender gaps.
      gaps_on = ((n / 200) % 4) != 3;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        load_entry(idx_t'($urandom_range(0, 15)),
                   ($urandom_range(0, 9) < 8) ? vec_pool[$urandom_range(0, VecPool - 1)]
                                              : rand_vec(),
                   ($urandom_range(0, 9) < 8) ? label_pool[$urandom_range(0, LabelPool - 1)]
                                              : rand_label());
      end else if (sel < 72) begin
        count_vec(($urandom_range(0, 99) < 85) ? vec_pool[$urandom_range(0, VecPool - 1)]
                                               : rand_vec());
      end else if (sel < 99) begin
        if ($urandom_range(0, 9) < 6) begin
          mr = lookup_class(vec_pool[$urandom_range(0, VecPool - 1)]);
          mc = lookup_class(vec_pool[$urandom_range(0, VecPool - 1)]);
          read_cell(mr.cls, mc.cls);
        end else begin
          read_cell(idx_t'($urandom_range(0, 15)), idx_t'($urandom_range(0, 15)));
        end
      end else begin
        clear_matrix();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_pair_counts();
    foreach (ent_valid[i]) ent_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_load_and_classify();
    test_pair_counting();
    test_clear();
    test_random_traffic();

    in_valid <= 1'b0;
    // let the monitor record the last accepted transaction first
    @(posedge clk_i);
    while (pair_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0)
      $display("vector_class_pair_count_matrix_top test passed");
    else
      $display("vector_class_pair_count_matrix_top test failed");
    $finish;
  end

endmodule
